/* hw/rtl/ksrq_pkg.sv */
// Shared types and constants for the keyboard scancode receive queue.
package ksrq_pkg;

   localparam int RING_DEPTH_DEF = 256;

   // Controller status bits.
   localparam logic [7:0] ST_OUTPUT_FULL = 8'h01;
   localparam logic [7:0] ST_AUX_DATA    = 8'h20;
   localparam logic [7:0] ST_ERRORS      = 8'hC0;

   // Request commands.
   localparam logic CMD_EVENT = 1'b0;
   localparam logic CMD_POP   = 1'b1;

   // Outcome codes reported with each response beat.
   localparam logic [2:0] OUT_NO_DATA   = 3'd0;
   localparam logic [2:0] OUT_AUX       = 3'd1;
   localparam logic [2:0] OUT_ERR_DROP  = 3'd2;
   localparam logic [2:0] OUT_FULL_DROP = 3'd3;
   localparam logic [2:0] OUT_STORED    = 3'd4;
   localparam logic [2:0] OUT_POPPED    = 3'd5;
   localparam logic [2:0] OUT_POP_EMPTY = 3'd6;

   typedef struct packed {
      logic       cmd;
      logic [7:0] status_byte;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [7:0]  popped_byte;
      logic [7:0]  fill_level;
      logic [31:0] event_total;
      logic [31:0] drop_total;
      logic [7:0]  newest_scancode;
   } rsp_type;

   // Commands from the front end to the ring.
   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] data;
   } ring_ctl_type;

   // Ring status: flags for the current pointers, level after this cycle's command.
   typedef struct packed {
      logic       empty;
      logic       full;
      logic [7:0] level;
   } ring_stat_type;

endpackage

/* hw/rtl/ksrq_ring.sv */
// Ring buffer storage, pointers and fill level for the scancode queue.
module ksrq_ring #(
   parameter int RING_DEPTH = ksrq_pkg::RING_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ksrq_pkg::ring_ctl_type ring_ctl,
   output ksrq_pkg::ring_stat_type ring_stat,
   output logic [7:0]             rd_data
);
   import ksrq_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_CNT = (PTR_W+1)'(RING_DEPTH);

   logic [7:0]       ring_mem_ff [RING_DEPTH];
   logic [7:0]       rd_data_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_next;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in, rd_next;
   logic [PTR_W:0]   fill_cnt;
   logic [31:0]      fill_wide;

   always_comb begin
      wr_next = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + PTR_W'(1);
      rd_next = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + PTR_W'(1);
      wr_ptr_in = ring_ctl.push ? wr_next : wr_ptr_ff;
      rd_ptr_in = ring_ctl.pop ? rd_next : rd_ptr_ff;
      if (wr_ptr_in >= rd_ptr_in) begin
         fill_cnt = {1'b0, wr_ptr_in} - {1'b0, rd_ptr_in};
      end else begin
         fill_cnt = DEPTH_CNT - {1'b0, rd_ptr_in} + {1'b0, wr_ptr_in};
      end
      fill_wide = 32'(fill_cnt);
   end

   assign ring_stat.empty = (wr_ptr_ff == rd_ptr_ff);
   assign ring_stat.full  = (wr_next == rd_ptr_ff);
   assign ring_stat.level = (fill_wide > 32'd255) ? 8'hFF : fill_wide[7:0];
   assign rd_data         = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Storage: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ring_ctl.push) begin
         ring_mem_ff[wr_ptr_ff] <= ring_ctl.data;
      end
      if (ring_ctl.pop) begin
         rd_data_ff <= ring_mem_ff[rd_ptr_ff];
      end
   end

endmodule

/* hw/rtl/keyboard_scancode_receive_queue.sv */
// Top level of the keyboard scancode receive queue.
//
// Each request beat is either a controller event (status and data byte from the
// keyboard controller) or a pop from the consumer, and each one yields exactly one
// response beat. An event is counted, then classified: no output-full means no
// data, the aux bit means the byte is ignored, an error bit drops it, and a clean
// byte becomes the newest scancode and is pushed into a ring that holds at most
// RING_DEPTH-1 bytes; a full ring drops it and counts the drop. A pop returns the
// oldest byte, or reports that the ring is empty. The block takes one beat per
// clock cycle when the response side keeps up. The accepting edge updates the
// pointers and counters, reads the ring and loads stage one; a later edge, once
// the output register is empty or its beat is being taken, forms the response
// from the ring's registered read data into the output register, which then
// presents the response beat. The ring contents need no clearing after reset;
// only bytes that were pushed are ever popped.
module keyboard_scancode_receive_queue #(
   parameter int RING_DEPTH = ksrq_pkg::RING_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ksrq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ksrq_pkg::rsp_type rsp_data
);
   import ksrq_pkg::*;

   // Architectural state that outlives a beat.
   logic [31:0] event_cnt_ff, event_cnt_in;
   logic [31:0] drop_cnt_ff, drop_cnt_in;
   logic [7:0]  newest_ff, newest_in;

   // Stage one holds the finished beat except for the popped byte, which
   // arrives from the ring's read register in the same cycle.
   logic    s1_valid_ff;
   logic    s1_pop_ff;
   rsp_type s1_rsp_ff, s1_rsp_in;

   // Output register.
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic          req_accept;
   logic          s1_move;
   logic          push_want, pop_want;
   logic [2:0]    outcome;
   ring_ctl_type  ring_ctl;
   ring_stat_type ring_stat;
   logic [7:0]    ring_rd_data;

   // Stage one drains into the output register when that register is empty or
   // its beat is being taken, so both sides can move in the same cycle.
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_move;
   assign req_accept = req_valid && req_ready;

   // Classify the incoming beat against the current ring and counters.
   always_comb begin
      event_cnt_in = event_cnt_ff;
      drop_cnt_in  = drop_cnt_ff;
      newest_in    = newest_ff;
      push_want    = 1'b0;
      pop_want     = 1'b0;
      outcome      = OUT_NO_DATA;
      if (req_data.cmd == CMD_POP) begin
         if (ring_stat.empty) begin
            outcome = OUT_POP_EMPTY;
         end else begin
            pop_want = 1'b1;
            outcome  = OUT_POPPED;
         end
      end else begin
         event_cnt_in = event_cnt_ff + 32'd1;
         if ((req_data.status_byte & ST_OUTPUT_FULL) == 8'h00) begin
            outcome = OUT_NO_DATA;
         end else if ((req_data.status_byte & ST_AUX_DATA) != 8'h00) begin
            // Aux wins over the error bits, so nothing is dropped here.
            outcome = OUT_AUX;
         end else if ((req_data.status_byte & ST_ERRORS) != 8'h00) begin
            drop_cnt_in = drop_cnt_ff + 32'd1;
            outcome     = OUT_ERR_DROP;
         end else begin
            // A clean byte is the newest scancode even if the ring cannot take it.
            newest_in = req_data.data_byte;
            if (ring_stat.full) begin
               drop_cnt_in = drop_cnt_ff + 32'd1;
               outcome     = OUT_FULL_DROP;
            end else begin
               push_want = 1'b1;
               outcome   = OUT_STORED;
            end
         end
      end
   end

   assign ring_ctl.push = req_accept && push_want;
   assign ring_ctl.pop  = req_accept && pop_want;
   assign ring_ctl.data = req_data.data_byte;

   ksrq_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .ring_ctl  (ring_ctl),
      .ring_stat (ring_stat),
      .rd_data   (ring_rd_data)
   );

   always_comb begin
      s1_rsp_in.outcome         = outcome;
      s1_rsp_in.popped_byte     = 8'h00;
      s1_rsp_in.fill_level      = ring_stat.level;
      s1_rsp_in.event_total     = event_cnt_in;
      s1_rsp_in.drop_total      = drop_cnt_in;
      s1_rsp_in.newest_scancode = newest_in;
   end

   // The popped byte joins the rest of the beat on its way to the output register.
   always_comb begin
      rsp_in             = s1_rsp_ff;
      rsp_in.popped_byte = s1_pop_ff ? ring_rd_data : 8'h00;
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         event_cnt_ff <= '0;
         drop_cnt_ff  <= '0;
         newest_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            event_cnt_ff <= event_cnt_in;
            drop_cnt_ff  <= drop_cnt_in;
            newest_ff    <= newest_in;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_rsp_ff <= s1_rsp_in;
         s1_pop_ff <= pop_want;
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/ksrq_checker.sv */
// Port-level checks for the keyboard scancode receive queue, bound to the top level.
module ksrq_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ksrq_pkg::rsp_type rsp_data
);
   import ksrq_pkg::*;

   // A stalled response beat holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // Reset leaves no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Only a successful pop carries a byte.
   a_popped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.outcome != OUT_POPPED) |-> rsp_data.popped_byte == 8'h00)
      else $error("popped byte set without a pop");

   // The fill level agrees with the outcome.
   a_fill_agrees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.outcome == OUT_STORED)
                    || (rsp_data.outcome == OUT_FULL_DROP)) |-> rsp_data.fill_level != 8'h00)
      else $error("ring reported empty after a store or full drop");

   a_empty_agrees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.outcome == OUT_POP_EMPTY) |-> rsp_data.fill_level == 8'h00)
      else $error("empty pop with a nonzero fill level");

endmodule

bind keyboard_scancode_receive_queue ksrq_checker u_ksrq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
